### sv/epcal_pkg.sv
// Shared types, constants and calendar helpers for the epoch-to-calendar unit.
`default_nettype none

package epcal_pkg;

   // Divider digit: quotient bits retired per cycle.
   localparam int unsigned DIGIT_BITS = 4;

   // Remainder width; holds any value below the largest divisor.
   localparam int unsigned REM_W = 18;

   // Output field widths.
   localparam int unsigned SEC_W  = 6;
   localparam int unsigned MIN_W  = 6;
   localparam int unsigned HOUR_W = 5;
   localparam int unsigned WDAY_W = 3;
   localparam int unsigned YEAR_W = 16;
   localparam int unsigned DOY_W  = 9;
   localparam int unsigned MON_W  = 4;
   localparam int unsigned DOM_W  = 5;

   // Year position inside the 400-year Gregorian cycle.
   localparam int unsigned YR400_W = 9;

   localparam logic [REM_W-1:0] SEC_PER_MIN  = 18'd60;
   localparam logic [REM_W-1:0] HOUR_PER_DAY = 18'd24;
   localparam logic [REM_W-1:0] CYCLE_DAYS   = 18'd146097;

   localparam logic [REM_W-1:0] DAYS_1Y   = 18'd365;
   localparam logic [REM_W-1:0] DAYS_4Y   = 18'd1460;
   localparam logic [REM_W-1:0] DAYS_100Y = 18'd36524;
   localparam logic [REM_W-1:0] DAYS_MAX_YEAR = 18'd366;

   localparam logic [WDAY_W:0]  DAYS_PER_WEEK = 4'd7;
   localparam logic [WDAY_W:0]  EPOCH_WEEKDAY = 4'd4;  // 1970-01-01 was a Thursday

   localparam logic [YEAR_W-1:0] BASE_YEAR_OFS = 16'd70;   // 1970 - 1900
   localparam logic [YEAR_W-1:0] CYCLE_YEARS   = 16'd400;
   localparam logic [YEAR_W-1:0] CENTURY_YEARS = 16'd100;
   localparam logic [YEAR_W-1:0] QUAD_YEARS    = 16'd4;
   localparam logic [YEAR_W-1:0] ONE_YEAR      = 16'd1;

   localparam logic [YR400_W-1:0] YR400_START  = 9'd370;  // 1970 mod 400
   localparam logic [YR400_W-1:0] YR400_WRAP   = 9'd400;
   localparam logic [YR400_W-1:0] YR400_C100   = 9'd100;
   localparam logic [YR400_W-1:0] YR400_C200   = 9'd200;
   localparam logic [YR400_W-1:0] YR400_C300   = 9'd300;

   localparam logic [MON_W-1:0] MON_JAN = 4'd0;
   localparam logic [MON_W-1:0] MON_FEB = 4'd1;
   localparam logic [MON_W-1:0] MON_APR = 4'd3;
   localparam logic [MON_W-1:0] MON_JUN = 4'd5;
   localparam logic [MON_W-1:0] MON_SEP = 4'd8;
   localparam logic [MON_W-1:0] MON_NOV = 4'd10;
   localparam logic [MON_W-1:0] MON_DEC = 4'd11;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_DIV_STEP,
      OP_TAKE_SEC,
      OP_TAKE_MIN,
      OP_TAKE_HOUR,
      OP_TAKE_CYCLE,
      OP_YEAR_STEP,
      OP_MONTH_INIT,
      OP_MONTH_STEP,
      OP_PUBLISH
   } dp_op_type;

   typedef enum logic [1:0] {
      DIV_60,
      DIV_24,
      DIV_CYCLE
   } div_sel_type;

   typedef struct packed {
      dp_op_type   op;
      div_sel_type div_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic year_done;
      logic month_done;
   } dp_status_type;

   typedef struct packed {
      logic [SEC_W-1:0]  second;
      logic [MIN_W-1:0]  minute;
      logic [HOUR_W-1:0] hour;
      logic [WDAY_W-1:0] weekday;
      logic [YEAR_W-1:0] years_since_1900;
      logic [DOY_W-1:0]  day_of_year;
      logic [MON_W-1:0]  month;
      logic [DOM_W-1:0]  day_of_month;
   } rsp_payload_type;

   // Gregorian leap rule on the year's position within its 400-year cycle.
   function automatic logic is_leap(input logic [YR400_W-1:0] yr400);
      return (yr400[1:0] == 2'b00) &&
             !(yr400 == YR400_C100 || yr400 == YR400_C200 || yr400 == YR400_C300);
   endfunction

   function automatic logic [DOM_W-1:0] month_days(input logic [MON_W-1:0] mon,
                                                   input logic leap);
      logic [DOM_W-1:0] len;
      len = 5'd31;
      if (mon == MON_FEB) begin
         len = leap ? 5'd29 : 5'd28;
      end else if (mon == MON_APR || mon == MON_JUN || mon == MON_SEP ||
                   mon == MON_NOV) begin
         len = 5'd30;
      end
      return len;
   endfunction

endpackage

`default_nettype wire

### sv/epcal_if.sv
// Handshake channels for the epoch-to-calendar unit: request and response.
`default_nettype none

interface epcal_req_if #(parameter int unsigned EPOCH_BITS = 40);
   logic                  valid;
   logic                  ready;
   logic [EPOCH_BITS-1:0] epoch_seconds;

   modport source (output valid, output epoch_seconds, input ready);
   modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface epcal_rsp_if;
   import epcal_pkg::*;

   logic              valid;
   logic              ready;
   logic [SEC_W-1:0]  second;
   logic [MIN_W-1:0]  minute;
   logic [HOUR_W-1:0] hour;
   logic [WDAY_W-1:0] weekday;
   logic [YEAR_W-1:0] years_since_1900;
   logic [DOY_W-1:0]  day_of_year;
   logic [MON_W-1:0]  month;
   logic [DOM_W-1:0]  day_of_month;

   modport source (output valid, output second, output minute, output hour,
                   output weekday, output years_since_1900, output day_of_year,
                   output month, output day_of_month, input ready);
   modport sink   (input valid, input second, input minute, input hour,
                   input weekday, input years_since_1900, input day_of_year,
                   input month, input day_of_month, output ready);
endinterface

`default_nettype wire

### sv/epcal_dp.sv
// Datapath: radix-16 constant divider, year and month walk, result register.
`default_nettype none

module epcal_dp #(
   parameter int unsigned EPOCH_BITS = 40
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [EPOCH_BITS-1:0]         epoch_seconds,
   input  epcal_pkg::dp_cmd_type         cmd,
   output epcal_pkg::dp_status_type      status,
   output epcal_pkg::rsp_payload_type    payload
);
   import epcal_pkg::*;

   localparam int unsigned STEPS = (EPOCH_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
   localparam int unsigned NUM_W = STEPS * DIGIT_BITS;

   // Dividend / quotient shift register and remainders.
   logic [NUM_W-1:0]   num_ff, num_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [WDAY_W-1:0]  rem7_ff, rem7_in;

   // Broken-down fields.
   logic [SEC_W-1:0]   sec_ff, sec_in;
   logic [MIN_W-1:0]   min_ff, min_in;
   logic [HOUR_W-1:0]  hour_ff, hour_in;
   logic [WDAY_W-1:0]  wday_ff, wday_in;
   logic [YEAR_W-1:0]  year_ff, year_in;
   logic [YR400_W-1:0] yr400_ff, yr400_in;
   logic [REM_W-1:0]   days_ff, days_in;
   logic [DOY_W-1:0]   doy_ff, doy_in;
   logic [MON_W-1:0]   mon_ff, mon_in;
   rsp_payload_type    payload_ff, payload_in;

   // Divider step.
   logic [REM_W-1:0]      divisor;
   logic [REM_W-1:0]      step_rem;
   logic [REM_W:0]        step_ext;
   logic [WDAY_W-1:0]     step_rem7;
   logic [WDAY_W:0]       step_ext7;
   logic [DIGIT_BITS-1:0] qbits;

   // Calendar walk.
   logic               cur_leap;
   logic [2:0]         leap_cnt;
   logic [REM_W-1:0]   len_1y, len_4y, len_100y, len_mon;
   logic [WDAY_W:0]    wday_sum;

   function automatic logic [YR400_W-1:0] yr_add(input logic [YR400_W-1:0] y,
                                                 input logic [YR400_W-1:0] inc);
      logic [YR400_W:0] sum;
      sum = {1'b0, y} + {1'b0, inc};
      if (sum >= {1'b0, YR400_WRAP}) begin
         sum = sum - {1'b0, YR400_WRAP};
      end
      return sum[YR400_W-1:0];
   endfunction

   always_comb begin
      unique case (cmd.div_sel)
         DIV_60:    divisor = SEC_PER_MIN;
         DIV_24:    divisor = HOUR_PER_DAY;
         DIV_CYCLE: divisor = CYCLE_DAYS;
         default:   divisor = CYCLE_DAYS;
      endcase
   end

   // One radix-16 digit per cycle; the mod-7 chain rides along for the weekday.
   always_comb begin
      step_rem  = rem_ff;
      step_rem7 = rem7_ff;
      step_ext  = '0;
      step_ext7 = '0;
      qbits     = '0;
      for (int i = 0; i < DIGIT_BITS; i++) begin
         step_ext = {step_rem, num_ff[NUM_W-1-i]};
         if (step_ext >= {1'b0, divisor}) begin
            step_ext = step_ext - {1'b0, divisor};
            qbits[DIGIT_BITS-1-i] = 1'b1;
         end
         step_rem = step_ext[REM_W-1:0];

         step_ext7 = {step_rem7, num_ff[NUM_W-1-i]};
         if (step_ext7 >= DAYS_PER_WEEK) begin
            step_ext7 = step_ext7 - DAYS_PER_WEEK;
         end
         step_rem7 = step_ext7[WDAY_W-1:0];
      end
   end

   always_comb begin
      leap_cnt = '0;
      for (int k = 0; k < 4; k++) begin
         leap_cnt = leap_cnt + 3'(is_leap(yr_add(yr400_ff, YR400_W'(k))));
      end
   end

   assign cur_leap = is_leap(yr400_ff);
   assign len_1y   = DAYS_1Y + REM_W'(cur_leap);
   assign len_4y   = DAYS_4Y + REM_W'(leap_cnt);
   // A century span holds an extra leap day when it covers a multiple of 400.
   assign len_100y = DAYS_100Y + REM_W'(yr400_ff == '0 || yr400_ff > YR400_C300);
   assign len_mon  = REM_W'(month_days(mon_ff, cur_leap));
   assign wday_sum = {1'b0, rem7_ff} + EPOCH_WEEKDAY;

   assign status.year_done  = (days_ff < len_1y);
   assign status.month_done = (days_ff < len_mon);

   always_comb begin
      num_in     = num_ff;
      rem_in     = rem_ff;
      rem7_in    = rem7_ff;
      sec_in     = sec_ff;
      min_in     = min_ff;
      hour_in    = hour_ff;
      wday_in    = wday_ff;
      year_in    = year_ff;
      yr400_in   = yr400_ff;
      days_in    = days_ff;
      doy_in     = doy_ff;
      mon_in     = mon_ff;
      payload_in = payload_ff;

      unique case (cmd.op)
         OP_LOAD: begin
            num_in  = NUM_W'(epoch_seconds);
            rem_in  = '0;
            rem7_in = '0;
         end
         OP_DIV_STEP: begin
            num_in  = {num_ff[NUM_W-DIGIT_BITS-1:0], qbits};
            rem_in  = step_rem;
            rem7_in = step_rem7;
         end
         OP_TAKE_SEC: begin
            sec_in  = rem_ff[SEC_W-1:0];
            rem_in  = '0;
            rem7_in = '0;
         end
         OP_TAKE_MIN: begin
            min_in  = rem_ff[MIN_W-1:0];
            rem_in  = '0;
            rem7_in = '0;
         end
         OP_TAKE_HOUR: begin
            hour_in = rem_ff[HOUR_W-1:0];
            rem_in  = '0;
            rem7_in = '0;
         end
         OP_TAKE_CYCLE: begin
            days_in  = rem_ff;
            year_in  = BASE_YEAR_OFS + YEAR_W'(num_ff[YEAR_W-1:0] * CYCLE_YEARS);
            yr400_in = YR400_START;
            wday_in  = (wday_sum >= DAYS_PER_WEEK) ? WDAY_W'(wday_sum - DAYS_PER_WEEK)
                                                   : wday_sum[WDAY_W-1:0];
         end
         OP_YEAR_STEP: begin
            priority if (days_ff >= len_100y) begin
               days_in  = days_ff - len_100y;
               year_in  = year_ff + CENTURY_YEARS;
               yr400_in = yr_add(yr400_ff, YR400_W'(CENTURY_YEARS));
            end else if (days_ff >= len_4y) begin
               days_in  = days_ff - len_4y;
               year_in  = year_ff + QUAD_YEARS;
               yr400_in = yr_add(yr400_ff, YR400_W'(QUAD_YEARS));
            end else if (days_ff >= len_1y) begin
               days_in  = days_ff - len_1y;
               year_in  = year_ff + ONE_YEAR;
               yr400_in = yr_add(yr400_ff, YR400_W'(ONE_YEAR));
            end
         end
         OP_MONTH_INIT: begin
            doy_in = days_ff[DOY_W-1:0];
            mon_in = MON_JAN;
         end
         OP_MONTH_STEP: begin
            days_in = days_ff - len_mon;
            mon_in  = mon_ff + 4'd1;
         end
         OP_PUBLISH: begin
            payload_in.second           = sec_ff;
            payload_in.minute           = min_ff;
            payload_in.hour             = hour_ff;
            payload_in.weekday          = wday_ff;
            payload_in.years_since_1900 = year_ff;
            payload_in.day_of_year      = doy_ff;
            payload_in.month            = mon_ff;
            payload_in.day_of_month     = DOM_W'(days_ff) + 5'd1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      num_ff     <= num_in;
      rem_ff     <= rem_in;
      rem7_ff    <= rem7_in;
      sec_ff     <= sec_in;
      min_ff     <= min_in;
      hour_ff    <= hour_in;
      wday_ff    <= wday_in;
      year_ff    <= year_in;
      yr400_ff   <= yr400_in;
      days_ff    <= days_in;
      doy_ff     <= doy_in;
      mon_ff     <= mon_in;
      payload_ff <= payload_in;
   end

   assign payload = payload_ff;

   // Remainder stays below the divisor on every digit step.
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_DIV_STEP) |-> (rem_ff < divisor))
      else $error("divider remainder out of range");

   // The 400-year skip leaves less than one cycle of days.
   a_cycle_days: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_TAKE_CYCLE) |=> (days_ff < CYCLE_DAYS))
      else $error("day count not below one 400-year cycle");

   // Each month step works on a day inside one year and a month before December.
   a_month_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_MONTH_STEP) |-> (days_ff < DAYS_MAX_YEAR && mon_ff < MON_DEC))
      else $error("month walk ran past December");

endmodule

`default_nettype wire

### sv/epcal_ctrl.sv
// Controller: sequences division passes, year and month walks, and the result slot.
`default_nettype none

module epcal_ctrl #(
   parameter int unsigned EPOCH_BITS = 40
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  epcal_pkg::dp_status_type  status,
   output epcal_pkg::dp_cmd_type     cmd
);
   import epcal_pkg::*;

   localparam int unsigned STEPS = (EPOCH_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
   localparam int unsigned CNT_W = $clog2(STEPS);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV,
      S_TAKE,
      S_YEAR,
      S_MONTH,
      S_PUBLISH
   } state_type;

   typedef enum logic [1:0] {
      PASS_SEC,
      PASS_MIN,
      PASS_HOUR,
      PASS_CYCLE
   } pass_type;

   state_type        state_ff, state_in;
   pass_type         pass_ff, pass_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      pass_in      = pass_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.op       = OP_NONE;
      req_ready    = (state_ff == S_IDLE);

      unique case (pass_ff)
         PASS_SEC:   cmd.div_sel = DIV_60;
         PASS_MIN:   cmd.div_sel = DIV_60;
         PASS_HOUR:  cmd.div_sel = DIV_24;
         PASS_CYCLE: cmd.div_sel = DIV_CYCLE;
         default:    cmd.div_sel = DIV_CYCLE;
      endcase

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               pass_in  = PASS_SEC;
               cnt_in   = CNT_W'(STEPS - 1);
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            cmd.op = OP_DIV_STEP;
            if (cnt_ff == '0) begin
               state_in = S_TAKE;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         S_TAKE: begin
            unique case (pass_ff)
               PASS_SEC:   cmd.op = OP_TAKE_SEC;
               PASS_MIN:   cmd.op = OP_TAKE_MIN;
               PASS_HOUR:  cmd.op = OP_TAKE_HOUR;
               PASS_CYCLE: cmd.op = OP_TAKE_CYCLE;
               default:    cmd.op = OP_TAKE_CYCLE;
            endcase
            if (pass_ff == PASS_CYCLE) begin
               state_in = S_YEAR;
            end else begin
               pass_in  = pass_type'(pass_ff + 2'd1);
               cnt_in   = CNT_W'(STEPS - 1);
               state_in = S_DIV;
            end
         end
         S_YEAR: begin
            if (status.year_done) begin
               cmd.op   = OP_MONTH_INIT;
               state_in = S_MONTH;
            end else begin
               cmd.op = OP_YEAR_STEP;
            end
         end
         S_MONTH: begin
            if (status.month_done) begin
               state_in = S_PUBLISH;
            end else begin
               cmd.op = OP_MONTH_STEP;
            end
         end
         S_PUBLISH: begin
            // Hold until the result slot is free or drains this cycle.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = OP_PUBLISH;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pass_ff      <= PASS_SEC;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pass_ff      <= pass_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // Never overwrite a result that has not been taken.
   a_slot_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_PUBLISH) |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten before it was taken");

   // An accepted item starts with the seconds pass.
   a_accept_start: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_DIV && pass_ff == PASS_SEC))
      else $error("accepted item did not start division");

   // A result appears only out of the publish step.
   a_valid_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_PUBLISH))
      else $error("result valid raised outside publish");

endmodule

`default_nettype wire

### sv/epoch_seconds_to_calendar_unit.sv
// Top level of the epoch-to-calendar unit: controller, datapath and channel wiring.
`default_nettype none

// Converts a non-negative count of seconds since 1970-01-01 00:00:00 UTC into
// second, minute, hour, weekday (0 is Sunday), years since 1900, zero-based day
// of year, zero-based month and one-based day of month, on the proleptic
// Gregorian calendar. Only the low EPOCH_BITS bits of the input are used; above
// 40 bits the year field wraps modulo 2^16 while every other field stays exact.
// The unit handles one item at a time. A shared radix-16 constant divider makes
// four passes (by 60, 60, 24 and by the 146097 days of a 400-year cycle, with
// the day count mod 7 taken along for the weekday), each a run of digit steps
// followed by a step that stores the remainder. The remaining days are then
// walked through years in steps of a century, four years or one year, and
// through months one per cycle. The publish step holds while the previous
// result still waits for the sink. The result sits in an output register, so
// the unit takes the next item while a finished result still waits for the
// sink. There are no configuration registers and no state kept between items.
module epoch_seconds_to_calendar_unit #(
   parameter int unsigned EPOCH_BITS = 40
) (
   input  logic        clock,
   input  logic        reset,
   epcal_req_if.sink   req_port,
   epcal_rsp_if.source rsp_port
);
   import epcal_pkg::*;

   dp_cmd_type      dp_cmd;
   dp_status_type   dp_status;
   rsp_payload_type dp_payload;
   logic [EPOCH_BITS-1:0] req_epoch;

   // Take only the used input bits.
   assign req_epoch = EPOCH_BITS'(req_port.epoch_seconds);

   epcal_ctrl #(
      .EPOCH_BITS (EPOCH_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_port.ready),
      .rsp_valid (rsp_port.valid),
      .rsp_ready (rsp_port.ready),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   epcal_dp #(
      .EPOCH_BITS (EPOCH_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .epoch_seconds (req_epoch),
      .cmd           (dp_cmd),
      .status        (dp_status),
      .payload       (dp_payload)
   );

   // Drive the result fields straight from the output register.
   assign rsp_port.second           = dp_payload.second;
   assign rsp_port.minute           = dp_payload.minute;
   assign rsp_port.hour             = dp_payload.hour;
   assign rsp_port.weekday          = dp_payload.weekday;
   assign rsp_port.years_since_1900 = dp_payload.years_since_1900;
   assign rsp_port.day_of_year      = dp_payload.day_of_year;
   assign rsp_port.month            = dp_payload.month;
   assign rsp_port.day_of_month     = dp_payload.day_of_month;

endmodule

`default_nettype wire

### tb/tb.sv
// Testbench for the epoch-to-calendar unit: stimulus, civil date predictor and result checks.
`timescale 1ns / 1ps

module tb;
   import epcal_pkg::*;

   localparam int unsigned EPOCH_BITS    = 40;
   localparam int unsigned RANDOM_ITEMS  = 1800;
   localparam int unsigned MAX_IDLE      = 11;
   // Allow for the worst item plus both idle draws, with a wide margin.
   localparam int unsigned QUIET_LIMIT   = 2000;
   localparam int unsigned DRAIN_CYCLES  = 120;
   localparam longint unsigned SEC_PER_DAY  = 86400;
   // Last day whose final second still fits in EPOCH_BITS.
   localparam longint unsigned LAST_FULL_DAY = 12725828;

   // Scoreboard: predicts the civil date of each accepted item and checks
   // results in order.
   class calendar_scoreboard;
      rsp_payload_type pending_dates[$];
      int unsigned     failures = 0;

      static function bit leap_year(input longint unsigned y);
         return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
      endfunction

      static function rsp_payload_type civil_date_of(input logic [EPOCH_BITS-1:0] epoch);
         longint unsigned t;
         longint unsigned days;
         longint unsigned year;
         int unsigned     mon;
         int unsigned     mlen;
         int unsigned     month_len[12];
         rsp_payload_type d;
         month_len = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
         t = longint'(epoch);
         d.second = SEC_W'(t % 60);
         t = t / 60;
         d.minute = MIN_W'(t % 60);
         t = t / 60;
         d.hour = HOUR_W'(t % 24);
         days = t / 24;
         // Day 0 was a Thursday.
         d.weekday = WDAY_W'((days % 7 + 4) % 7);
         // Skip whole 400-year cycles, then walk single years.
         year = 1970 + (days / 146097) * 400;
         days = days % 146097;
         while (days >= (leap_year(year) ? 366 : 365)) begin
            days = days - (leap_year(year) ? 366 : 365);
            year = year + 1;
         end
         d.years_since_1900 = YEAR_W'(year - 1900);
         d.day_of_year = DOY_W'(days);
         for (mon = 0; mon < 12; mon++) begin
            mlen = month_len[mon];
            if (mon == 1 && leap_year(year)) begin
               mlen = mlen + 1;
            end
            if (days < mlen) begin
               break;
            end
            days = days - mlen;
         end
         if (mon > 11) begin
            mon = 11;
         end
         d.month = MON_W'(mon);
         d.day_of_month = DOM_W'(days + 1);
         return d;
      endfunction

      function void note_seconds(input logic [EPOCH_BITS-1:0] epoch);
         pending_dates.push_back(civil_date_of(epoch));
      endfunction

      function void compare_field(input string field, input longint unsigned want,
                                  input longint unsigned got);
         if (want != got) begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            failures++;
         end
      endfunction

      function void check_date(input rsp_payload_type got);
         rsp_payload_type want;
         if (pending_dates.size() == 0) begin
            $error("result with no item outstanding");
            failures++;
            return;
         end
         want = pending_dates.pop_front();
         compare_field("second", want.second, got.second);
         compare_field("minute", want.minute, got.minute);
         compare_field("hour", want.hour, got.hour);
         compare_field("weekday", want.weekday, got.weekday);
         compare_field("years_since_1900", want.years_since_1900, got.years_since_1900);
         compare_field("day_of_year", want.day_of_year, got.day_of_year);
         compare_field("month", want.month, got.month);
         compare_field("day_of_month", want.day_of_month, got.day_of_month);
      endfunction
   endclass

   logic clock;
   logic reset;

   epcal_req_if #(.EPOCH_BITS(EPOCH_BITS)) req_bus ();
   epcal_rsp_if rsp_bus ();

   epoch_seconds_to_calendar_unit #(.EPOCH_BITS(EPOCH_BITS)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus.sink),
      .rsp_port (rsp_bus.source)
   );

   calendar_scoreboard sb = new;

   // Each side runs in stretches with no idling, switched at random.
   bit req_no_idle = 1'b0;
   bit rsp_no_idle = 1'b0;

   initial begin
      clock = 1'b0;
      forever begin
         #2 clock = ~clock;
      end
   end

   function automatic int unsigned idle_draw(input bit no_idle);
      return no_idle ? 0 : $urandom_range(0, MAX_IDLE);
   endfunction

   // Present one item; hold valid through back-pressure until it is taken.
   task automatic send_seconds(input logic [EPOCH_BITS-1:0] epoch);
      int unsigned gap;
      if ($urandom_range(0, 63) == 0) begin
         req_no_idle = ~req_no_idle;
      end
      gap = idle_draw(req_no_idle);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.epoch_seconds <= epoch;
      do begin
         @(posedge clock);
      end while (!req_bus.ready);
      sb.note_seconds(epoch);
   endtask

   // Take one result; first hold ready low for a random idle gap, skipped in a no-idle stretch.
   task automatic take_result();
      int unsigned     gap;
      rsp_payload_type got;
      if ($urandom_range(0, 63) == 0) begin
         rsp_no_idle = ~rsp_no_idle;
      end
      gap = idle_draw(rsp_no_idle);
      if (gap > 0) begin
         rsp_bus.ready <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      rsp_bus.ready <= 1'b1;
      do begin
         @(posedge clock);
      end while (!rsp_bus.valid);
      got.second           = rsp_bus.second;
      got.minute           = rsp_bus.minute;
      got.hour             = rsp_bus.hour;
      got.weekday          = rsp_bus.weekday;
      got.years_since_1900 = rsp_bus.years_since_1900;
      got.day_of_year      = rsp_bus.day_of_year;
      got.month            = rsp_bus.month;
      got.day_of_month     = rsp_bus.day_of_month;
      sb.check_date(got);
   endtask

   // Random item drawn from a mix of ranges: full width, 32-bit, day edges, the first
   // 2^26 seconds, the top of the range and whole days.
   function automatic logic [EPOCH_BITS-1:0] random_seconds();
      longint unsigned day;
      longint unsigned pick;
      logic [EPOCH_BITS-1:0] full;
      full = {8'($urandom_range(0, 255)), 32'($urandom())};
      pick = $urandom_range(0, 9);
      day  = $urandom_range(0, LAST_FULL_DAY);
      case (pick)
         0, 1, 2, 3: begin
            return full;
         end
         4, 5: begin
            return EPOCH_BITS'($urandom());
         end
         6: begin
            // Land on the first or last seconds of a day.
            case ($urandom_range(0, 3))
               0: return EPOCH_BITS'(day * SEC_PER_DAY);
               1: return EPOCH_BITS'(day * SEC_PER_DAY + 1);
               2: return EPOCH_BITS'(day * SEC_PER_DAY + SEC_PER_DAY - 2);
               default: return EPOCH_BITS'(day * SEC_PER_DAY + SEC_PER_DAY - 1);
            endcase
         end
         7: begin
            return EPOCH_BITS'($urandom_range(0, 32'h03FF_FFFF));
         end
         8: begin
            return {EPOCH_BITS{1'b1}} - EPOCH_BITS'($urandom_range(0, 32'h03FF_FFFF));
         end
         default: begin
            // Whole days only: midnight, exercising the date walk alone.
            return EPOCH_BITS'(($urandom_range(0, 32'hFFFF_FFFF) % (LAST_FULL_DAY + 1))
                               * SEC_PER_DAY);
         end
      endcase
   endfunction

   // Watchdog: end the run when nothing moves for too long.
   initial begin
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("FAILURE");
      $finish;
   end

   initial begin
      logic [EPOCH_BITS-1:0] directed_seconds[$];
      directed_seconds = '{
         40'd0, 40'd1, 40'd59, 40'd60, 40'd3599, 40'd3600, 40'd86399, 40'd86400,
         40'hFF_FFFF_FFFF, 40'h55_5555_5555, 40'hAA_AAAA_AAAA,
         40'd68169600,      // 1972-02-29, first leap day
         40'd68256000,      // 1972-03-01
         40'd94694399,      // last second of 1972, day 365 of the year
         40'd946684799,     // last second of 1999
         40'd951782400,     // 2000-02-29, leap by the 400-year rule
         40'd978307199,     // last second of 2000
         40'd4107542399,    // 2100-02-28, century year is not leap
         40'd4107542400,    // 2100-03-01
         40'd12622780800,   // 2370-01-01, one whole 400-year cycle skipped
         40'd13574563200,   // 2400-02-29
         40'd2147483647, 40'd4294967295, 40'd4294967296
      };

      reset                 <= 1'b1;
      req_bus.valid         <= 1'b0;
      req_bus.epoch_seconds <= '0;
      rsp_bus.ready         <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      fork
         forever begin
            take_result();
         end
      join_none

      foreach (directed_seconds[i]) begin
         send_seconds(directed_seconds[i]);
      end
      repeat (RANDOM_ITEMS) begin
         send_seconds(random_seconds());
      end
      req_bus.valid <= 1'b0;

      // Drain: wait for every predicted date, then watch for strays.
      while (sb.pending_dates.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.failures == 0 && sb.pending_dates.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
